// ----- rtl/vna_pkg.sv -----
`default_nettype none
package vna_pkg;

	localparam int IDX_W         = 12;
	localparam int POS_W         = 24;
	localparam int SUM_W         = 56;
	localparam int NRM_W         = 16;
	localparam int CNT_W         = 13;
	localparam int MAX_VERTS_DEF = 4096;
	localparam logic [CNT_W-1:0] VCOUNT_RESET = 13'd4096;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_TRI   = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_POS_RD,
		ST_POS_LAST,
		ST_DIFF,
		ST_MUL,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_NORM_RD,
		ST_NORM_LD,
		ST_NORM_MAX,
		ST_NORM_SHIFT,
		ST_SQUARE,
		ST_SQRT,
		ST_DIV_INIT,
		ST_DIV_STEP,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

// ----- rtl/vna_ifs.sv -----
`default_nettype none
interface vna_cmd_if import vna_pkg::*;;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [IDX_W-1:0]  vertex_index;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic [IDX_W-1:0]  corner_a;
	logic [IDX_W-1:0]  corner_b;
	logic [IDX_W-1:0]  corner_c;

	modport source (output valid, kind, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, input ready);
	modport sink (input valid, kind, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, output ready);
endinterface

interface vna_rsp_if import vna_pkg::*;;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  read_index;
	logic signed [NRM_W-1:0] normal_x;
	logic signed [NRM_W-1:0] normal_y;
	logic signed [NRM_W-1:0] normal_z;
	logic              index_error;

	modport source (output valid, read_index, normal_x, normal_y, normal_z,
		index_error, input ready);
	modport sink (input valid, read_index, normal_x, normal_y, normal_z,
		index_error, output ready);
endinterface
`default_nettype wire

// ----- rtl/vna_ram.sv -----
`default_nettype none
module vna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/vertex_normal_accumulator.sv -----
// Area-weighted smooth vertex normals. Requests on cmd: kind 0 stores a vertex
// position (24-bit signed, 8 fraction bits) and clears its normal sum; kind 1 adds the
// cross product (b-a)x(c-a) of a triangle to each corner's 56-bit saturating sum;
// kind 2 returns that vertex's sum scaled to unit length in Q1.14 on rsp (zero for a
// zero sum). Any index at or beyond min(vertex_count, MAX_VERTS) gives a result with
// index_error set and zero normals, and changes nothing; kind 3 is dropped. A triangle
// with one bad corner adds nothing. One request is in work at a time; a new one is
// taken while a finished result still waits in the output register. Steps from one
// accept to the next: a position write is decoded and stored; a triangle runs decode,
// three position reads, a pass through one shared 25x25 multiplier, three
// read-modify-write passes over the sum memory and a return to idle; a read runs
// decode, the sum read, sign and magnitude load, a pick of the largest magnitude,
// one-bit shifts that bring it into [2^29, 2^30), squaring, a bit-serial square root
// and a restoring divide per axis, then emits the result and returns to idle. The
// emit waits while the output register still holds a result the receiver has not
// taken. Positions sit in one 72-bit memory and sums in one 168-bit memory, both with
// registered reads. Reading a vertex never written since reset returns undefined data.
`default_nettype none
module vertex_normal_accumulator import vna_pkg::*; #(
	parameter int MAX_VERTS = MAX_VERTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	vna_cmd_if.sink           cmd,
	vna_rsp_if.source         rsp
);
	localparam int AW  = $clog2(MAX_VERTS);
	localparam int EW  = ($clog2(MAX_VERTS + 1) > CNT_W) ? $clog2(MAX_VERTS + 1) : CNT_W;
	localparam int PW  = 3 * POS_W;
	localparam int SW  = 3 * SUM_W;
	localparam int DW  = POS_W + 1;      // edge component
	localparam int MW  = 2 * DW;         // edge product
	localparam int NW  = MW + 1;         // cross product component
	localparam int RW  = 63;             // square root working width
	localparam int QW  = 46;             // divider working width

	// control
	state_t state_q, state_d;
	logic [2:0] cnt_q;
	logic [4:0] step_q;
	logic [CNT_W-1:0] vcount_q;
	logic [EW-1:0] eff_cnt;
	logic err_vi, err_tri;

	// request
	kind_t kind_q;
	logic [IDX_W-1:0] vidx_q;
	logic [PW-1:0] posw_q;
	logic [IDX_W-1:0] corner_q [3];

	// triangle datapath
	logic signed [POS_W-1:0] p_q [3][3];   // [corner][axis]
	logic signed [DW-1:0] u_q [3];
	logic signed [DW-1:0] v_q [3];
	logic signed [DW-1:0] mul_a, mul_b;
	logic signed [MW-1:0] prod_q;
	logic signed [NW-1:0] ncr_q [3];
	logic [1:0] acc_axis;

	// normalize datapath
	logic [SUM_W-1:0] mag_q [3];
	logic neg_q [3];
	logic [SUM_W-1:0] big_q;
	logic [59:0] sqp_q;
	logic [61:0] sq_q;
	logic [RW-1:0] rx_q, rr_q, bitv, rt;
	logic [QW-1:0] num_q, den_q;
	logic [14:0] quo_q;
	logic div_ge;
	logic [14:0] quo_fin;

	// result staging and output register
	logic [IDX_W-1:0] res_index_q;
	logic signed [NRM_W-1:0] res_n_q [3];
	logic res_err_q;
	logic rsp_valid_q;
	logic [IDX_W-1:0] rsp_index_q;
	logic signed [NRM_W-1:0] rsp_n_q [3];
	logic rsp_err_q;
	logic emit_go;

	// memories
	logic pos_we, sum_we;
	logic [AW-1:0] pos_waddr, pos_raddr, sum_waddr, sum_raddr;
	logic [PW-1:0] pos_rdata;
	logic [SW-1:0] sum_wdata, sum_rdata, sum_new;

	vna_ram #(.WIDTH(PW), .DEPTH(MAX_VERTS)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(posw_q),
		.raddr(pos_raddr), .rdata(pos_rdata)
	);

	vna_ram #(.WIDTH(SW), .DEPTH(MAX_VERTS)) u_sum_ram (
		.clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
		.raddr(sum_raddr), .rdata(sum_rdata)
	);

	// range checks against the effective vertex count
	assign eff_cnt = (EW'(vcount_q) < EW'(MAX_VERTS)) ? EW'(vcount_q) : EW'(MAX_VERTS);
	assign err_vi  = EW'(vidx_q) >= eff_cnt;
	assign err_tri = (EW'(corner_q[0]) >= eff_cnt) || (EW'(corner_q[1]) >= eff_cnt) ||
		(EW'(corner_q[2]) >= eff_cnt);

	assign acc_axis = 2'((cnt_q - 3'd1) >> 1);

	// saturating accumulate of the cross product into the corner's sum
	always_comb begin
		logic signed [SUM_W:0] s;
		logic signed [SUM_W-1:0] a;
		for (int k = 0; k < 3; k++) begin
			a = sum_rdata[(2-k)*SUM_W +: SUM_W];
			s = (SUM_W+1)'(a) + (SUM_W+1)'(ncr_q[k]);
			if (s[SUM_W] != s[SUM_W-1]) begin
				sum_new[(2-k)*SUM_W +: SUM_W] = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
					: {1'b0, {(SUM_W-1){1'b1}}};
			end else begin
				sum_new[(2-k)*SUM_W +: SUM_W] = s[SUM_W-1:0];
			end
		end
	end

	// multiplier operand order: x=uy*vz-uz*vy, y=uz*vx-ux*vz, z=ux*vy-uy*vx
	always_comb begin
		mul_a = u_q[1];
		mul_b = v_q[2];
		case (cnt_q)
			3'd0: begin mul_a = u_q[1]; mul_b = v_q[2]; end
			3'd1: begin mul_a = u_q[2]; mul_b = v_q[1]; end
			3'd2: begin mul_a = u_q[2]; mul_b = v_q[0]; end
			3'd3: begin mul_a = u_q[0]; mul_b = v_q[2]; end
			3'd4: begin mul_a = u_q[0]; mul_b = v_q[1]; end
			3'd5: begin mul_a = u_q[1]; mul_b = v_q[0]; end
			default: begin mul_a = u_q[1]; mul_b = v_q[2]; end
		endcase
	end

	// square root step
	assign bitv = RW'(1) << {step_q, 1'b0};
	assign rt   = rr_q + bitv;

	// divider step
	assign div_ge  = num_q >= den_q;
	assign quo_fin = {quo_q[13:0], div_ge};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (kind_q)
					KIND_WRITE: state_d = err_vi ? ST_EMIT : ST_IDLE;
					KIND_TRI:   state_d = err_tri ? ST_EMIT : ST_POS_RD;
					KIND_READ:  state_d = err_vi ? ST_EMIT : ST_NORM_RD;
					default:    state_d = ST_IDLE;
				endcase
			end
			ST_POS_RD:   if (cnt_q == 3'd2) state_d = ST_POS_LAST;
			ST_POS_LAST: state_d = ST_DIFF;
			ST_DIFF:     state_d = ST_MUL;
			ST_MUL:      if (cnt_q == 3'd6) state_d = ST_ACC_RD;
			ST_ACC_RD:   state_d = ST_ACC_WR;
			ST_ACC_WR:   state_d = (cnt_q == 3'd2) ? ST_IDLE : ST_ACC_RD;
			ST_NORM_RD:  state_d = ST_NORM_LD;
			ST_NORM_LD:  state_d = ST_NORM_MAX;
			ST_NORM_MAX: state_d = ST_NORM_SHIFT;
			ST_NORM_SHIFT: begin
				if (big_q == '0) state_d = ST_EMIT;
				else if (big_q[SUM_W-1:30] == '0 && big_q[29]) state_d = ST_SQUARE;
			end
			ST_SQUARE:   if (cnt_q == 3'd3) state_d = ST_SQRT;
			ST_SQRT:     if (step_q == '0) state_d = ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV_STEP;
			ST_DIV_STEP: begin
				if (step_q == '0) state_d = (cnt_q == 3'd2) ? ST_EMIT : ST_DIV_INIT;
			end
			ST_EMIT:     if (!rsp_valid_q || rsp.ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory and handshake controls
	always_comb begin
		pos_we    = 1'b0;
		sum_we    = 1'b0;
		pos_waddr = AW'(vidx_q);
		sum_waddr = AW'(vidx_q);
		sum_wdata = '0;
		pos_raddr = AW'(corner_q[cnt_q[1:0]]);
		sum_raddr = AW'(corner_q[cnt_q[1:0]]);
		emit_go   = 1'b0;
		cmd.ready = 1'b0;
		case (state_q)
			ST_IDLE:   cmd.ready = 1'b1;
			ST_DECODE: begin
				if (kind_q == KIND_WRITE && !err_vi) begin
					pos_we = 1'b1;
					sum_we = 1'b1;
				end
			end
			ST_ACC_WR: begin
				sum_we    = 1'b1;
				sum_waddr = AW'(corner_q[cnt_q[1:0]]);
				sum_wdata = sum_new;
			end
			ST_NORM_RD: sum_raddr = AW'(vidx_q);
			ST_EMIT:    emit_go = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vcount_q    <= VCOUNT_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) vcount_q <= cfg_wdata;
			if (emit_go) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			kind_q      <= kind_t'(cmd.kind);
			vidx_q      <= cmd.vertex_index;
			posw_q      <= {cmd.pos_x, cmd.pos_y, cmd.pos_z};
			corner_q[0] <= cmd.corner_a;
			corner_q[1] <= cmd.corner_b;
			corner_q[2] <= cmd.corner_c;
		end
		if (emit_go) begin
			rsp_index_q <= res_index_q;
			rsp_n_q     <= res_n_q;
			rsp_err_q   <= res_err_q;
		end
		case (state_q)
			ST_DECODE: begin
				cnt_q       <= '0;
				res_index_q <= (kind_q == KIND_TRI) ? '0 : vidx_q;
				res_err_q   <= 1'b1;
				if (kind_q == KIND_READ && !err_vi) res_err_q <= 1'b0;
				for (int k = 0; k < 3; k++) res_n_q[k] <= '0;
			end
			ST_POS_RD, ST_POS_LAST: begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q != '0) begin
					p_q[cnt_q[1:0] - 2'd1][0] <= pos_rdata[2*POS_W +: POS_W];
					p_q[cnt_q[1:0] - 2'd1][1] <= pos_rdata[POS_W +: POS_W];
					p_q[cnt_q[1:0] - 2'd1][2] <= pos_rdata[0 +: POS_W];
				end
			end
			ST_DIFF: begin
				cnt_q <= '0;
				for (int k = 0; k < 3; k++) begin
					u_q[k] <= DW'(p_q[1][k]) - DW'(p_q[0][k]);
					v_q[k] <= DW'(p_q[2][k]) - DW'(p_q[0][k]);
				end
			end
			ST_MUL: begin
				cnt_q  <= (cnt_q == 3'd6) ? '0 : cnt_q + 3'd1;
				prod_q <= mul_a * mul_b;
				if (cnt_q != '0) begin
					if (cnt_q[0]) ncr_q[acc_axis] <= NW'(prod_q);
					else ncr_q[acc_axis] <= ncr_q[acc_axis] - NW'(prod_q);
				end
			end
			ST_ACC_WR: cnt_q <= cnt_q + 3'd1;
			ST_NORM_LD: begin
				for (int k = 0; k < 3; k++) begin
					neg_q[k] <= sum_rdata[(2-k)*SUM_W + SUM_W - 1];
					mag_q[k] <= sum_rdata[(2-k)*SUM_W + SUM_W - 1]
						? SUM_W'(0) - sum_rdata[(2-k)*SUM_W +: SUM_W]
						: sum_rdata[(2-k)*SUM_W +: SUM_W];
				end
			end
			ST_NORM_MAX: begin
				if (mag_q[0] >= mag_q[1] && mag_q[0] >= mag_q[2]) big_q <= mag_q[0];
				else if (mag_q[1] >= mag_q[2]) big_q <= mag_q[1];
				else big_q <= mag_q[2];
			end
			ST_NORM_SHIFT: begin
				cnt_q <= '0;
				if (big_q[SUM_W-1:30] != '0) begin
					big_q <= big_q >> 1;
					for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] >> 1;
				end else if (!big_q[29] && big_q != '0) begin
					big_q <= big_q << 1;
					for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] << 1;
				end
			end
			ST_SQUARE: begin
				cnt_q  <= (cnt_q == 3'd3) ? '0 : cnt_q + 3'd1;
				step_q <= 5'd31;
				if (cnt_q != 3'd3) sqp_q <= mag_q[cnt_q[1:0]][29:0] * mag_q[cnt_q[1:0]][29:0];
				if (cnt_q == 3'd1) sq_q <= 62'(sqp_q);
				if (cnt_q == 3'd2) sq_q <= sq_q + 62'(sqp_q);
				if (cnt_q == 3'd3) begin
					rx_q <= RW'(sq_q + 62'(sqp_q));
					rr_q <= '0;
				end
			end
			ST_SQRT: begin
				step_q <= step_q - 5'd1;
				if (rx_q >= rt) begin
					rx_q <= rx_q - rt;
					rr_q <= (rr_q >> 1) + bitv;
				end else begin
					rr_q <= rr_q >> 1;
				end
			end
			ST_DIV_INIT: begin
				step_q <= 5'd14;
				quo_q  <= '0;
				num_q  <= {2'b00, mag_q[cnt_q[1:0]][29:0], 14'd0} + QW'(rr_q[31:1]);
				den_q  <= {rr_q[31:0], 14'd0};
			end
			ST_DIV_STEP: begin
				step_q <= step_q - 5'd1;
				quo_q  <= quo_fin;
				den_q  <= den_q >> 1;
				if (div_ge) num_q <= num_q - den_q;
				if (step_q == '0) begin
					cnt_q <= cnt_q + 3'd1;
					res_n_q[cnt_q[1:0]] <= neg_q[cnt_q[1:0]] ? NRM_W'(0) - NRM_W'(quo_fin)
						: NRM_W'(quo_fin);
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.read_index  = rsp_index_q;
	assign rsp.normal_x    = rsp_n_q[0];
	assign rsp.normal_y    = rsp_n_q[1];
	assign rsp.normal_z    = rsp_n_q[2];
	assign rsp.index_error = rsp_err_q;

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> state_q == ST_DECODE)
		else $error("accepted request not decoded");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.index_error |->
		rsp.normal_x == '0 && rsp.normal_y == '0 && rsp.normal_z == '0)
		else $error("flagged result carries nonzero normal");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV_INIT |-> rr_q[RW-1:32] == '0 && rr_q[31:29] != '0)
		else $error("vector length out of normalized range");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.index_error |->
		rsp.normal_x >= -16'sd16384 && rsp.normal_x <= 16'sd16384 &&
		rsp.normal_y >= -16'sd16384 && rsp.normal_y <= 16'sd16384 &&
		rsp.normal_z >= -16'sd16384 && rsp.normal_z <= 16'sd16384)
		else $error("normal component beyond unit");
endmodule
`default_nettype wire

// ----- test/vertex_normal_accumulator_test.sv -----
`default_nettype none
module vertex_normal_accumulator_test;
	import vna_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// One command as it sits on the cmd channel.
	typedef struct {
		kind_t                    kind;
		logic [IDX_W-1:0]         vidx;
		logic signed [POS_W-1:0]  px, py, pz;
		logic [IDX_W-1:0]         ca, cb, cc;
	} mesh_req_t;

	// One normal (or error) result as it leaves on rsp.
	typedef struct {
		logic [IDX_W-1:0]         idx;
		logic signed [NRM_W-1:0]  nx, ny, nz;
		logic                     err;
	} normal_rsp_t;

	localparam int  NV         = MAX_VERTS_DEF;
	localparam int  QUIET_MAX  = 20000;    // cycles with no handshake before giving up
	localparam int  HOLD_LEN   = 3000;     // long receiver hold-off
	localparam int  DRAIN_WAIT = 200;      // longest request is a read
	localparam longint SUM_HI  = (64'sd1 <<< (SUM_W-1)) - 1;
	localparam longint SUM_LO  = -(64'sd1 <<< (SUM_W-1));

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	vna_cmd_if cmd_bus();
	vna_rsp_if rsp_bus();

	vertex_normal_accumulator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_bus),
		.rsp       (rsp_bus)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// ------------------------------------------------------------------
	// Mirror of the block's state: positions, 56-bit sums and the count.
	// ------------------------------------------------------------------
	logic signed [POS_W-1:0] mir_px [NV];
	logic signed [POS_W-1:0] mir_py [NV];
	logic signed [POS_W-1:0] mir_pz [NV];
	longint mir_sx [NV];
	longint mir_sy [NV];
	longint mir_sz [NV];
	int unsigned mir_count = VCOUNT_RESET;

	mesh_req_t   pending_q[$];   // requests still to be offered
	normal_rsp_t normal_exp_q[$];  // results still owed by the block
	mesh_req_t   on_bus;          // request currently offered

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 0;
	int errors = 0;
	int reqs_sent = 0;
	int results_seen = 0;
	int quiet_cycles = 0;

	function automatic longint sat_acc(longint a, longint b);
		longint s;
		s = a + b;
		if (s > SUM_HI) return SUM_HI;
		if (s < SUM_LO) return SUM_LO;
		return s;
	endfunction

	// Scale a sum to unit length in Q1.14: bring the biggest magnitude to 30 bits,
	// integer square root of the squared length, rounded divide per axis.
	function automatic normal_rsp_t unit_normal(longint sx, longint sy, longint sz);
		normal_rsp_t r;
		longint unsigned m[3];
		longint s[3];
		longint unsigned big, sq, len, rem, root, bitv, q;
		int b;
		s[0] = sx; s[1] = sy; s[2] = sz;
		big = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = (s[i] < 0) ? longint'(-s[i]) : longint'(s[i]);
			if (m[i] > big) big = m[i];
		end
		r.idx = '0; r.err = 1'b0; r.nx = '0; r.ny = '0; r.nz = '0;
		if (big == 0) return r;
		b = 0;
		while ((big >> b) != 0) b++;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			if (b < 30) m[i] = m[i] << (30 - b);
			else m[i] = m[i] >> (b - 30);
			sq += m[i] * m[i];
		end
		rem = sq; root = 0; bitv = 64'd1 << 62;
		while (bitv > rem) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		len = root;
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 64'd16384 + (len >> 1)) / len;
			if (s[i] < 0) q = -q;
			if (i == 0) r.nx = q[15:0];
			else if (i == 1) r.ny = q[15:0];
			else r.nz = q[15:0];
		end
		return r;
	endfunction

	// Apply one accepted request to the mirror and queue the result it owes.
	task automatic predict_request(mesh_req_t t);
		normal_rsp_t r;
		int unsigned n;
		longint ux, uy, uz, vx, vy, vz, nx, ny, nz;
		int unsigned c[3];
		n = (mir_count < NV) ? mir_count : NV;
		r.idx = '0; r.nx = '0; r.ny = '0; r.nz = '0; r.err = 1'b1;
		case (t.kind)
			KIND_WRITE: begin
				if (t.vidx >= n) begin
					r.idx = t.vidx;
					normal_exp_q.push_back(r);
				end else begin
					mir_px[t.vidx] = t.px; mir_py[t.vidx] = t.py; mir_pz[t.vidx] = t.pz;
					mir_sx[t.vidx] = 0; mir_sy[t.vidx] = 0; mir_sz[t.vidx] = 0;
				end
			end
			KIND_TRI: begin
				c[0] = t.ca; c[1] = t.cb; c[2] = t.cc;
				if (c[0] >= n || c[1] >= n || c[2] >= n) begin
					normal_exp_q.push_back(r);
				end else begin
					ux = longint'(mir_px[c[1]]) - mir_px[c[0]];
					uy = longint'(mir_py[c[1]]) - mir_py[c[0]];
					uz = longint'(mir_pz[c[1]]) - mir_pz[c[0]];
					vx = longint'(mir_px[c[2]]) - mir_px[c[0]];
					vy = longint'(mir_py[c[2]]) - mir_py[c[0]];
					vz = longint'(mir_pz[c[2]]) - mir_pz[c[0]];
					nx = uy * vz - uz * vy;
					ny = uz * vx - ux * vz;
					nz = ux * vy - uy * vx;
					for (int e = 0; e < 3; e++) begin
						mir_sx[c[e]] = sat_acc(mir_sx[c[e]], nx);
						mir_sy[c[e]] = sat_acc(mir_sy[c[e]], ny);
						mir_sz[c[e]] = sat_acc(mir_sz[c[e]], nz);
					end
				end
			end
			KIND_READ: begin
				if (t.vidx >= n) begin
					r.idx = t.vidx;
				end else begin
					r = unit_normal(mir_sx[t.vidx], mir_sy[t.vidx], mir_sz[t.vidx]);
					r.idx = t.vidx;
				end
				normal_exp_q.push_back(r);
			end
			default: ;  // kind 3 is dropped by the block
		endcase
	endtask

	// ------------------------------------------------------------------
	// Driver: offers requests from pending_q with random idle cycles.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_bus.valid        <= 1'b0;
			cmd_bus.kind         <= KIND_NONE;
			cmd_bus.vertex_index <= '0;
			cmd_bus.pos_x        <= '0;
			cmd_bus.pos_y        <= '0;
			cmd_bus.pos_z        <= '0;
			cmd_bus.corner_a     <= '0;
			cmd_bus.corner_b     <= '0;
			cmd_bus.corner_c     <= '0;
		end else begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				predict_request(on_bus);
				reqs_sent++;
			end
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					on_bus = pending_q.pop_front();
					cmd_bus.valid        <= 1'b1;
					cmd_bus.kind         <= on_bus.kind;
					cmd_bus.vertex_index <= on_bus.vidx;
					cmd_bus.pos_x        <= on_bus.px;
					cmd_bus.pos_y        <= on_bus.py;
					cmd_bus.pos_z        <= on_bus.pz;
					cmd_bus.corner_a     <= on_bus.ca;
					cmd_bus.corner_b     <= on_bus.cb;
					cmd_bus.corner_c     <= on_bus.cc;
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result against the oldest expectation and
	// drives rsp.ready, including the long hold-off when asked for.
	// ------------------------------------------------------------------
	int hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		normal_rsp_t want;
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				results_seen++;
				if (normal_exp_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result idx=%0d n=(%0d,%0d,%0d) err=%0b", $realtime,
						rsp_bus.read_index, rsp_bus.normal_x, rsp_bus.normal_y,
						rsp_bus.normal_z, rsp_bus.index_error);
				end else begin
					want = normal_exp_q.pop_front();
					if (rsp_bus.read_index !== want.idx) begin
						errors++;
						$display("%0t: read_index exp %0d got %0d", $realtime, want.idx,
							rsp_bus.read_index);
					end
					if (rsp_bus.normal_x !== want.nx) begin
						errors++;
						$display("%0t: normal_x idx %0d exp %0d got %0d", $realtime, want.idx,
							want.nx, rsp_bus.normal_x);
					end
					if (rsp_bus.normal_y !== want.ny) begin
						errors++;
						$display("%0t: normal_y idx %0d exp %0d got %0d", $realtime, want.idx,
							want.ny, rsp_bus.normal_y);
					end
					if (rsp_bus.normal_z !== want.nz) begin
						errors++;
						$display("%0t: normal_z idx %0d exp %0d got %0d", $realtime, want.idx,
							want.nz, rsp_bus.normal_z);
					end
					if (rsp_bus.index_error !== want.err) begin
						errors++;
						$display("%0t: index_error idx %0d exp %0b got %0b", $realtime, want.idx,
							want.err, rsp_bus.index_error);
					end
				end
			end
			// hold-off: counted here, started by the stimulus flag
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_LEN;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: any stretch with no handshake on either side this long is a hang.
	always @(posedge clk) begin
		if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("timeout: no request or result moved for %0d cycles", QUIET_MAX);
			$display("vertex_normal_accumulator_test: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus side. gen_live tracks which vertices have a stored position,
	// so a triangle or read never touches an entry that was never written.
	// ------------------------------------------------------------------
	bit gen_live [NV];
	int gen_live_list[$];

	function automatic logic signed [POS_W-1:0] rand_pos();
		case ($urandom_range(0, 3))
			0: return POS_W'($signed($urandom_range(0, 2000)) - 1000);
			1: return POS_W'($urandom);
			2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
			default: return POS_W'($signed($urandom_range(0, 200000)) - 100000);
		endcase
	endfunction

	function automatic mesh_req_t blank_req(kind_t k);
		mesh_req_t t;
		t.kind = k;
		t.vidx = IDX_W'($urandom);
		t.px = POS_W'($urandom); t.py = POS_W'($urandom); t.pz = POS_W'($urandom);
		t.ca = IDX_W'($urandom); t.cb = IDX_W'($urandom); t.cc = IDX_W'($urandom);
		return t;
	endfunction

	function automatic void add_write(int idx, logic signed [POS_W-1:0] x,
			logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z);
		mesh_req_t t;
		t = blank_req(KIND_WRITE);
		t.vidx = IDX_W'(idx); t.px = x; t.py = y; t.pz = z;
		if (idx < ((mir_count < NV) ? mir_count : NV) && !gen_live[idx]) begin
			gen_live[idx] = 1;
			gen_live_list.push_back(idx);
		end
		pending_q.push_back(t);
	endfunction

	function automatic void add_tri(int a, int b, int c);
		mesh_req_t t;
		t = blank_req(KIND_TRI);
		t.ca = IDX_W'(a); t.cb = IDX_W'(b); t.cc = IDX_W'(c);
		pending_q.push_back(t);
	endfunction

	function automatic void add_read(int idx);
		mesh_req_t t;
		t = blank_req(KIND_READ);
		t.vidx = IDX_W'(idx);
		pending_q.push_back(t);
	endfunction

	// A written vertex below the current count, or -1.
	function automatic int pick_live();
		int unsigned n;
		int v;
		n = (mir_count < NV) ? mir_count : NV;
		if (gen_live_list.size() == 0) return -1;
		for (int k = 0; k < 8; k++) begin
			v = gen_live_list[$urandom_range(0, gen_live_list.size() - 1)];
			if (v < n) return v;
		end
		return -1;
	endfunction

	// An index that is safe to name: live, or out of range.
	function automatic int safe_index();
		int unsigned n;
		int v;
		n = (mir_count < NV) ? mir_count : NV;
		v = $urandom_range(0, NV - 1);
		if (v >= n || gen_live[v]) return v;
		return pick_live();
	endfunction

	function automatic void add_random(int count);
		int unsigned n, hot;
		int a, b, c, r;
		mesh_req_t t;
		n = (mir_count < NV) ? mir_count : NV;
		hot = (n == 0) ? 1 : ((n < 48) ? n : 48);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 25 || pick_live() < 0) begin
				if ($urandom_range(0, 9) == 0) a = $urandom_range(0, NV - 1);
				else a = $urandom_range(0, hot - 1);
				add_write(a, rand_pos(), rand_pos(), rand_pos());
			end else if (r < 62) begin
				a = pick_live(); b = pick_live(); c = pick_live();
				case ($urandom_range(0, 19))
					0: b = a;
					1: c = b;
					2: c = safe_index();
					3: a = safe_index();
					default: ;
				endcase
				if (a < 0 || b < 0 || c < 0) add_write(0, rand_pos(), rand_pos(), rand_pos());
				else add_tri(a, b, c);
			end else if (r < 95) begin
				a = ($urandom_range(0, 9) == 0) ? safe_index() : pick_live();
				if (a < 0) a = pick_live();
				add_read(a);
			end else begin
				t = blank_req(KIND_NONE);
				pending_q.push_back(t);
			end
		end
	endfunction

	// Drive the sums of vertices 0, 1 and 2 into saturation: an extreme triangle
	// adds about 2^48 per pass, so ~140 passes pin the 56-bit clamp.
	function automatic void add_saturation_burst(bit flip);
		add_write(0, 24'sh800000, 24'sh800000, 24'sh0);
		add_write(1, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
		add_write(2, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
		for (int i = 0; i < 140; i++) begin
			if (flip) add_tri(0, 2, 1);
			else add_tri(0, 1, 2);
		end
		add_read(0); add_read(1); add_read(2);
	endfunction

	// Idle means everything offered, every result back, and the engine quiet.
	task automatic wait_drained();
		while (pending_q.size() != 0 || cmd_bus.valid || normal_exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_vertex_count(int unsigned v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v[CNT_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		mir_count = v & 13'h1FFF;
	endtask

	// per phase: vertex_count, idle mode (0 none, 1 sender, 2 receiver, 3 both)
	int unsigned phase_cnt [9] = '{4096, 4096, 16, 1, 0, 5000, 8191, 300, 4096};
	int          phase_mode[9] = '{0, 1, 0, 2, 3, 0, 2, 1, 3};

	initial begin
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < 9; p++) begin
			set_vertex_count(phase_cnt[p]);
			case (phase_mode[p])
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			if (p == 0) begin
				// extremes, both triangle windings, degenerate and repeated corners,
				// a zero sum, and the unused kind
				add_write(0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
				add_write(1, 24'sh800000, 24'sh800000, 24'sh7FFFFF);
				add_write(2, 24'sh000000, 24'sh800000, 24'sh000100);
				add_write(4095, 24'sh123456, 24'shFEDCBA, 24'sh000000);
				add_write(3, 24'sh000100, 24'sh000000, 24'sh000000);
				add_tri(0, 1, 2);
				add_tri(2, 1, 0);
				add_tri(0, 0, 1);
				add_tri(0, 1, 1);
				add_tri(4095, 4095, 4095);
				add_read(0); add_read(1); add_read(2); add_read(4095); add_read(3);
				pending_q.push_back(blank_req(KIND_NONE));
				add_tri(3, 2, 0);
				add_read(3);
				add_write(0, 24'sh000001, 24'sh000000, 24'sh000000);
				add_read(0);
			end else if (p == 2) begin
				// out of range against a small count, with the receiver held off
				add_write(16, rand_pos(), rand_pos(), rand_pos());
				add_read(4095);
				add_tri(0, 0, 20);
				hold_req = 1;
				add_random(240);
			end else if (p == 1 || p == 6) begin
				add_saturation_burst(p == 6);
				add_random(200);
			end else if (p == 4) begin
				add_random(120);  // every index flagged
			end else begin
				add_random(240);
			end
			wait_drained();
		end

		$display("covered %0d requests over 9 count settings (incl. 0, 1, 8191), %0d results",
			reqs_sent, results_seen);
		$display("saturation bursts, out-of-range indices, and all four idle modes exercised");
		if (errors == 0) begin
			$display("vertex_normal_accumulator_test: PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("vertex_normal_accumulator_test: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/vna_pkg.sv
rtl/vna_ifs.sv
rtl/vna_ram.sv
rtl/vertex_normal_accumulator.sv
test/vertex_normal_accumulator_test.sv
